### hdl/i2cms_pkg.sv
// Package for the I2C master bit sequencer: step encoding, opcodes, register
// indexes, reset values and the pin level record.
// No dependencies.
`default_nettype none

package i2cms_pkg;

  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned PhaseWidth  = 10;
  localparam int unsigned PollWidth   = 8;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned BitIdxWidth = 4;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgWidth    = PhaseWidth;

  localparam logic [OpcodeWidth-1:0] OP_TICK  = 3'd0;
  localparam logic [OpcodeWidth-1:0] OP_START = 3'd1;
  localparam logic [OpcodeWidth-1:0] OP_STOP  = 3'd2;
  localparam logic [OpcodeWidth-1:0] OP_WRITE = 3'd3;
  localparam logic [OpcodeWidth-1:0] OP_READ  = 3'd4;

  localparam logic [CfgIdxWidth-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [PhaseWidth-1:0] PHASE_TICKS_RESET = 10'd5;
  localparam logic [PollWidth-1:0]  ACK_TIMEOUT_RESET = 8'd250;

  typedef enum logic [4:0] {
    S_IDLE    = 5'd0,
    S_ST_A    = 5'd1,
    S_ST_B    = 5'd2,
    S_SP_A    = 5'd3,
    S_SP_B    = 5'd4,
    S_SP_C    = 5'd5,
    S_FS_A    = 5'd6,
    S_FS_B    = 5'd7,
    S_FS_C    = 5'd8,
    S_WB_SET  = 5'd9,
    S_WB_HI   = 5'd10,
    S_WB_LO   = 5'd11,
    S_WA_REL  = 5'd12,
    S_WA_HI   = 5'd13,
    S_WA_POLL = 5'd14,
    S_WA_END  = 5'd15,
    S_RB_LO   = 5'd16,
    S_RB_HI   = 5'd17,
    S_RA_LO   = 5'd18,
    S_RA_HI   = 5'd19
  } step_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

  function automatic pins_t mk_pins(input logic scl, input logic sda, input logic drv);
    pins_t p;
    p.scl = scl;
    p.sda = sda;
    p.drv = drv;
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: steps SCL and SDA through start, stop, write-byte
// and read-byte sequences, one input beat per clock while the result stream
// is not stalled. Depends on i2cms_pkg. A result beat appears in the cycle
// after its input beat is accepted. The sequencer state and the result register
// both update in the cycle of acceptance, so nothing iterates per beat.
// Reset (rst, synchronous): idle, SCL and SDA high and driven, counters cleared,
// registers back to phase_ticks 5 and ack_timeout 250, no result pending.
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [i2cms_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire logic [i2cms_pkg::CfgWidth-1:0]      cfg_data,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // tx_byte[7:0], send_ack, sda_in, zero pad
  input  wire logic [2:0]  s_axis_tuser,  // opcode
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // scl_out, sda_out, sda_drive, busy_res,
                                          // done_res, ack_failed, read_data[7:0],
                                          // rejected, zero pad
);

  // configuration registers
  logic [i2cms_pkg::PhaseWidth-1:0] phase_ticks;
  logic [i2cms_pkg::PollWidth-1:0]  ack_timeout;

  // sequencer state
  i2cms_pkg::step_t                  step, step_next;
  logic [i2cms_pkg::PhaseWidth-1:0]  tick_cnt, tick_cnt_next;
  logic [i2cms_pkg::BitIdxWidth-1:0] bit_idx, bit_idx_next;
  logic [i2cms_pkg::ByteWidth-1:0]   shift_reg, shift_reg_next;
  logic [i2cms_pkg::PollWidth-1:0]   poll_cnt, poll_cnt_next;
  logic                              ack_choice, ack_choice_next;
  i2cms_pkg::pins_t                  pins, pins_next;
  logic [i2cms_pkg::ByteWidth-1:0]   rx_byte, rx_byte_next;

  // result register
  logic done_next, fail_next, rej_next;
  logic res_done, res_fail, res_rej, res_busy;

  // input beat fields
  logic [i2cms_pkg::OpcodeWidth-1:0] opcode;
  logic [i2cms_pkg::ByteWidth-1:0]   tx_byte;
  logic                              send_ack;
  logic                              sda_in;
  logic                              in_acc;
  logic [i2cms_pkg::PhaseWidth-1:0]  tick_inc;

  assign opcode   = s_axis_tuser;
  assign tx_byte  = s_axis_tdata[7:0];
  assign send_ack = s_axis_tdata[8];
  assign sda_in   = s_axis_tdata[9];

  // The result register frees up in the same cycle that its beat is taken.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tick_inc      = tick_cnt + 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cms_pkg::PHASE_TICKS_RESET;
      ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cms_pkg::CFG_PHASE_TICKS: phase_ticks <= cfg_data;
        i2cms_pkg::CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[i2cms_pkg::PollWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= i2cms_pkg::S_IDLE;
      tick_cnt   <= '0;
      bit_idx    <= '0;
      shift_reg  <= '0;
      poll_cnt   <= '0;
      ack_choice <= 1'b0;
      pins       <= i2cms_pkg::mk_pins(1'b1, 1'b1, 1'b1);
      rx_byte    <= '0;
    end else if (in_acc) begin
      step       <= step_next;
      tick_cnt   <= tick_cnt_next;
      bit_idx    <= bit_idx_next;
      shift_reg  <= shift_reg_next;
      poll_cnt   <= poll_cnt_next;
      ack_choice <= ack_choice_next;
      pins       <= pins_next;
      rx_byte    <= rx_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result payload: pins and read byte come straight from the state registers,
  // which only move on an accepted beat, so they hold while the result stalls.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_done <= done_next;
      res_fail <= fail_next;
      res_rej  <= rej_next;
      res_busy <= (step_next != i2cms_pkg::S_IDLE);
    end
  end

  assign m_axis_tdata = {1'b0, res_rej, rx_byte, res_fail, res_done, res_busy,
                         pins.drv, pins.sda, pins.scl};

  always_comb begin
    step_next       = step;
    tick_cnt_next   = tick_cnt;
    bit_idx_next    = bit_idx;
    shift_reg_next  = shift_reg;
    poll_cnt_next   = poll_cnt;
    ack_choice_next = ack_choice;
    pins_next       = pins;
    rx_byte_next    = rx_byte;
    done_next       = 1'b0;
    fail_next       = 1'b0;
    rej_next        = 1'b0;

    if (opcode == i2cms_pkg::OP_START || opcode == i2cms_pkg::OP_STOP ||
        opcode == i2cms_pkg::OP_WRITE || opcode == i2cms_pkg::OP_READ) begin
      if (step != i2cms_pkg::S_IDLE) begin
        rej_next = 1'b1;
      end else begin
        tick_cnt_next = '0;
        unique case (opcode)
          i2cms_pkg::OP_START: begin
            step_next = i2cms_pkg::S_ST_A;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b1, 1'b1);
          end
          i2cms_pkg::OP_STOP: begin
            step_next = i2cms_pkg::S_SP_A;
            pins_next = i2cms_pkg::mk_pins(1'b0, 1'b0, 1'b1);
          end
          i2cms_pkg::OP_WRITE: begin
            shift_reg_next = tx_byte;
            bit_idx_next   = '0;
            step_next      = i2cms_pkg::S_WB_SET;
            pins_next      = i2cms_pkg::mk_pins(1'b0, tx_byte[7], 1'b1);
          end
          default: begin
            shift_reg_next  = '0;
            bit_idx_next    = '0;
            ack_choice_next = send_ack;
            step_next       = i2cms_pkg::S_RB_LO;
            pins_next       = i2cms_pkg::mk_pins(1'b0, 1'b1, 1'b0);
          end
        endcase
      end
    end else if (opcode == i2cms_pkg::OP_TICK && step != i2cms_pkg::S_IDLE) begin
      if (step == i2cms_pkg::S_WA_POLL) begin
        // The acknowledge poll is timed by samples, not by phase ticks.
        if (!sda_in) begin
          step_next     = i2cms_pkg::S_WA_END;
          tick_cnt_next = '0;
          pins_next     = i2cms_pkg::mk_pins(1'b0, 1'b1, 1'b0);
        end else if (poll_cnt >= ack_timeout) begin
          step_next     = i2cms_pkg::S_FS_A;
          tick_cnt_next = '0;
          pins_next     = i2cms_pkg::mk_pins(1'b0, 1'b0, 1'b1);
        end else begin
          poll_cnt_next = poll_cnt + 8'd1;
        end
      end else if (tick_inc < phase_ticks) begin
        tick_cnt_next = tick_inc;
      end else begin
        tick_cnt_next = '0;
        unique case (step)
          i2cms_pkg::S_ST_A: begin
            step_next = i2cms_pkg::S_ST_B;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b0, 1'b1);
          end
          i2cms_pkg::S_ST_B: begin
            pins_next.scl = 1'b0;
            step_next     = i2cms_pkg::S_IDLE;
            done_next     = 1'b1;
          end
          i2cms_pkg::S_SP_A: begin
            step_next = i2cms_pkg::S_SP_B;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b0, 1'b1);
          end
          i2cms_pkg::S_SP_B: begin
            step_next = i2cms_pkg::S_SP_C;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b1, 1'b1);
          end
          i2cms_pkg::S_SP_C: begin
            step_next = i2cms_pkg::S_IDLE;
            done_next = 1'b1;
          end
          i2cms_pkg::S_FS_A: begin
            step_next = i2cms_pkg::S_FS_B;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b0, 1'b1);
          end
          i2cms_pkg::S_FS_B: begin
            step_next = i2cms_pkg::S_FS_C;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b1, 1'b1);
          end
          i2cms_pkg::S_FS_C: begin
            step_next = i2cms_pkg::S_IDLE;
            done_next = 1'b1;
            fail_next = 1'b1;
          end
          i2cms_pkg::S_WB_SET: begin
            step_next     = i2cms_pkg::S_WB_HI;
            pins_next.scl = 1'b1;
          end
          i2cms_pkg::S_WB_HI: begin
            step_next     = i2cms_pkg::S_WB_LO;
            pins_next.scl = 1'b0;
          end
          i2cms_pkg::S_WB_LO: begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_idx_next   = bit_idx + 4'd1;
            if (bit_idx_next[3]) begin
              step_next = i2cms_pkg::S_WA_REL;
              pins_next = i2cms_pkg::mk_pins(1'b0, 1'b1, 1'b0);
            end else begin
              step_next = i2cms_pkg::S_WB_SET;
              pins_next = i2cms_pkg::mk_pins(1'b0, shift_reg[6], 1'b1);
            end
          end
          i2cms_pkg::S_WA_REL: begin
            step_next = i2cms_pkg::S_WA_HI;
            pins_next = i2cms_pkg::mk_pins(1'b1, 1'b1, 1'b0);
          end
          i2cms_pkg::S_WA_HI: begin
            step_next     = i2cms_pkg::S_WA_POLL;
            poll_cnt_next = '0;
          end
          i2cms_pkg::S_WA_END: begin
            step_next = i2cms_pkg::S_IDLE;
            done_next = 1'b1;
          end
          i2cms_pkg::S_RB_LO: begin
            // SDA is sampled on the beat that raises SCL.
            step_next      = i2cms_pkg::S_RB_HI;
            pins_next      = i2cms_pkg::mk_pins(1'b1, 1'b1, 1'b0);
            shift_reg_next = {shift_reg[6:0], sda_in};
            bit_idx_next   = bit_idx + 4'd1;
          end
          i2cms_pkg::S_RB_HI: begin
            if (bit_idx[3]) begin
              rx_byte_next = shift_reg;
              step_next    = i2cms_pkg::S_RA_LO;
              pins_next    = i2cms_pkg::mk_pins(1'b0, !ack_choice, 1'b1);
            end else begin
              step_next = i2cms_pkg::S_RB_LO;
              pins_next = i2cms_pkg::mk_pins(1'b0, 1'b1, 1'b0);
            end
          end
          i2cms_pkg::S_RA_LO: begin
            step_next     = i2cms_pkg::S_RA_HI;
            pins_next.scl = 1'b1;
          end
          i2cms_pkg::S_RA_HI: begin
            pins_next.scl = 1'b0;
            step_next     = i2cms_pkg::S_IDLE;
            done_next     = 1'b1;
          end
          default: begin
            step_next = i2cms_pkg::S_IDLE;
          end
        endcase
      end
    end
  end

  // A failed acknowledge is only ever reported as part of a completion.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_fail) |-> res_done)
    else $error("ack_failed without done");

  // Completion and rejection cannot come from the same beat.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res_done && res_rej))
    else $error("done and rejected together");

  // SDA must be released for the whole acknowledge poll.
  assert property (@(posedge clk) disable iff (rst)
    (step == i2cms_pkg::S_WA_POLL) |-> !pins.drv)
    else $error("SDA driven during acknowledge poll");

  // A rejected command leaves the sequence step untouched.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && rej_next) |=> (step == $past(step)))
    else $error("rejected command changed the step");

endmodule

`default_nettype wire
